[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the RTL files, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared sizes, types and codes of the label collision filter.
// ----------------------------------------------------------------------------
package lcf_pkg;

    localparam int MAX_RECTS  = 256;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int LIMIT_W    = 16;
    localparam logic [LIMIT_W-1:0] KEPT_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_rect;

    // word walking along the cell row: candidate plus running overlap flag
    typedef struct packed {
        t_rect rect;
        logic  hit;
    } t_probe;

    typedef enum logic [1:0] {
        R_KEPT    = 2'd0,
        R_LIMIT   = 2'd1,
        R_OVERLAP = 2'd2,
        R_FULL    = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

endpackage

[rtl/lcf_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf channel interfaces
// Valid/ready channels for candidate words in and verdict words out.
// ----------------------------------------------------------------------------
interface lcf_in_if
    import lcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               first_of_frame;
    logic               rect_valid;
    t_coord             rect_min_x;
    t_coord             rect_min_y;
    t_coord             rect_max_x;
    t_coord             rect_max_y;
    logic               limit_enabled;
    logic [LIMIT_W-1:0] feature_limit;

    modport source (
        output valid, first_of_frame, rect_valid, rect_min_x, rect_min_y,
               rect_max_x, rect_max_y, limit_enabled, feature_limit,
        input  ready
    );
    modport sink (
        input  valid, first_of_frame, rect_valid, rect_min_x, rect_min_y,
               rect_max_x, rect_max_y, limit_enabled, feature_limit,
        output ready
    );
endinterface

interface lcf_out_if;
    logic       valid;
    logic       ready;
    logic       keep;
    logic [1:0] drop_reason;

    modport source (output valid, keep, drop_reason, input ready);
    modport sink (input valid, keep, drop_reason, output ready);
endinterface

[rtl/lcf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_cell
// One slot of the rectangle store: holds one accepted rectangle, tests the
// passing candidate against it and hands the word on to the next slot.
// ----------------------------------------------------------------------------
module lcf_cell
    import lcf_pkg::*;
(
    input  logic   i_clk,
    input  t_probe i_probe,
    input  logic   i_active,
    input  logic   i_wr_en,
    input  t_rect  i_wr_rect,
    output t_probe o_probe
);

    t_rect  r_rect;
    t_probe r_probe;
    logic   meet;

    // touching edges count as overlap
    always_comb begin
        meet = !((i_probe.rect.x1 < r_rect.x0) || (i_probe.rect.x0 > r_rect.x1) ||
                 (i_probe.rect.y1 < r_rect.y0) || (i_probe.rect.y0 > r_rect.y1));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rect <= i_wr_rect;
        end
        r_probe.rect <= i_probe.rect;
        r_probe.hit  <= i_probe.hit | (i_active & meet);
    end

    assign o_probe = r_probe;

endmodule

[rtl/lcf_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_chain
// Row of MAX_RECTS store cells; slots below the fill count take part in the
// overlap test, the slot at the fill count takes the next stored rectangle.
// ----------------------------------------------------------------------------
module lcf_chain
    import lcf_pkg::*;
(
    input  logic             i_clk,
    input  t_probe           i_probe,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_rect            i_wr_rect,
    output t_probe           o_probe
);

    t_probe w_probe [MAX_RECTS+1];

    assign w_probe[0] = i_probe;

    for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
        lcf_cell u_cell (
            .i_clk     (i_clk),
            .i_probe   (w_probe[g]),
            .i_active  (CNT_W'(g) < i_count),
            .i_wr_en   (i_wr_en && (i_wr_idx == IDX_W'(g))),
            .i_wr_rect (i_wr_rect),
            .o_probe   (w_probe[g+1])
        );
    end

    assign o_probe = w_probe[MAX_RECTS];

endmodule

[rtl/label_collision_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_collision_filter_core
// Greedy label placement: limit test, rectangle overlap rejection, store.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one label candidate per word, in priority order; o_out
//   returns one verdict word (keep, drop_reason) per candidate, in order.
//   first_of_frame on a candidate empties the rectangle store and the kept
//   count before that candidate is judged.
// Flow:
//   A candidate with a valid rectangle that passes the limit test walks the
//   row of MAX_RECTS store cells, one cell per cycle; the next candidate is
//   taken only once its verdict has moved to the output register. Candidates
//   dropped by the limit or carrying no rectangle are judged at once, without
//   the walk. One candidate is in work at a time.
// Reset:
//   Synchronous, active low; empties the store (fill count zero), clears the
//   kept count and the output valid flag. Store contents are not cleared.
// Stall:
//   A verdict held in the output register does not block the next candidate;
//   the following verdict waits in the block until the output frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module label_collision_filter_core
    import lcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lcf_in_if.sink    i_in,
    lcf_out_if.source o_out
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_scan_cnt, n_scan_cnt;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [LIMIT_W-1:0] r_kept, n_kept;
    t_rect              r_cand, n_cand;
    logic               r_lim_en, n_lim_en;
    t_reason            r_reason, n_reason;
    logic               r_out_valid, n_out_valid;
    t_reason            r_out_reason, n_out_reason;

    logic               accept;
    logic [CNT_W-1:0]   eff_count;
    logic [LIMIT_W-1:0] eff_kept;
    logic [LIMIT_W-1:0] kept_base;
    logic [LIMIT_W-1:0] kept_sat;
    logic               over_limit;
    logic               wr_en;
    t_probe             probe_in;
    t_probe             probe_out;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign eff_count  = i_in.first_of_frame ? '0 : r_count;
    assign eff_kept   = i_in.first_of_frame ? '0 : r_kept;
    assign over_limit = i_in.limit_enabled && (eff_kept > i_in.feature_limit);
    assign kept_base  = (r_state == S_IDLE) ? eff_kept : r_kept;
    assign kept_sat   = (kept_base == KEPT_MAX) ? kept_base : kept_base + 1'b1;

    assign probe_in.rect = r_cand;
    assign probe_in.hit  = 1'b0;

    lcf_chain u_chain (
        .i_clk     (i_clk),
        .i_probe   (probe_in),
        .i_count   (r_count),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_count[IDX_W-1:0]),
        .i_wr_rect (r_cand),
        .o_probe   (probe_out)
    );

    always_comb begin
        n_state      = r_state;
        n_scan_cnt   = r_scan_cnt;
        n_count      = r_count;
        n_kept       = r_kept;
        n_cand       = r_cand;
        n_lim_en     = r_lim_en;
        n_reason     = r_reason;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_reason = r_out_reason;
        wr_en        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count    = eff_count;
                    n_kept     = eff_kept;
                    n_cand     = '{x0: i_in.rect_min_x, y0: i_in.rect_min_y,
                                   x1: i_in.rect_max_x, y1: i_in.rect_max_y};
                    n_lim_en   = i_in.limit_enabled;
                    n_scan_cnt = '0;
                    if (over_limit) begin
                        n_reason = R_LIMIT;
                        n_state  = S_WAIT;
                    end else if (!i_in.rect_valid) begin
                        n_reason = R_KEPT;
                        if (i_in.limit_enabled) begin
                            n_kept = kept_sat;
                        end
                        n_state = S_WAIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                // row is flushed once the candidate has reached the last cell
                if (r_scan_cnt == CNT_W'(MAX_RECTS)) begin
                    if (probe_out.hit) begin
                        n_reason = R_OVERLAP;
                    end else if (r_count == CNT_W'(MAX_RECTS)) begin
                        n_reason = R_FULL;
                    end else begin
                        n_reason = R_KEPT;
                        wr_en    = 1'b1;
                        n_count  = r_count + 1'b1;
                        if (r_lim_en) begin
                            n_kept = kept_sat;
                        end
                    end
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_reason = r_reason;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_count     <= '0;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_cnt  <= n_scan_cnt;
            r_count     <= n_count;
            r_kept      <= n_kept;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand       <= n_cand;
        r_lim_en     <= n_lim_en;
        r_reason     <= n_reason;
        r_out_reason <= n_out_reason;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.keep        = (r_out_reason == R_KEPT);
    assign o_out.drop_reason = r_out_reason;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_RECTS), "fill count past store size")
    `ASSERT_IMPL(a_wr_room, i_clk, i_rst_n, wr_en, r_count < CNT_W'(MAX_RECTS), "store write while full")
    `ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, accept, !i_in.ready, "second word taken while one in work")
    `ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_scan_cnt <= CNT_W'(MAX_RECTS), "scan ran past the cell row")

endmodule
